### design/bit_aligned_raster_op_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the raster op core
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BIT_ALIGNED_RASTER_OP_CORE_MACROS_SVH
`define BIT_ALIGNED_RASTER_OP_CORE_MACROS_SVH

`ifndef SYNTH

// condition must never hold
`define BAR_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("raster op core: forbidden condition seen");

// antecedent implies consequent in the same cycle
`define BAR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("raster op core: implication failed");

// antecedent implies consequent in the next cycle
`define BAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("raster op core: next-cycle implication failed");

`else

`define BAR_ASSERT_NEVER(label, cond)
`define BAR_ASSERT_IMPLY(label, ante, cons)
`define BAR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### design/bar_pkg.sv
// ---------------------------------------------------------------------------
// bar_pkg
// Shared types, register indexes, operation codes and byte helpers.
// ---------------------------------------------------------------------------
package bar_pkg;

    localparam int LENGTH_WIDTH_DEF = 20;
    localparam int CFG_ADDR_W       = 3;
    localparam int INDEX_W          = 18;
    localparam int FIFO_DEPTH       = 8;
    localparam int FIFO_PTR_W       = 3;
    localparam int FIFO_CNT_W       = 4;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BOOL_OP     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_X_OFFSET    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_Y_OFFSET    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEST_OFFSET = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LENGTH      = 3'd4;

    // boolean operation codes
    localparam logic [3:0] OP_CLR   = 4'd0;
    localparam logic [3:0] OP_SET   = 4'd1;
    localparam logic [3:0] OP_1     = 4'd2;
    localparam logic [3:0] OP_2     = 4'd3;
    localparam logic [3:0] OP_C1    = 4'd4;
    localparam logic [3:0] OP_C2    = 4'd5;
    localparam logic [3:0] OP_AND   = 4'd6;
    localparam logic [3:0] OP_IOR   = 4'd7;
    localparam logic [3:0] OP_XOR   = 4'd8;
    localparam logic [3:0] OP_EQV   = 4'd9;
    localparam logic [3:0] OP_NAND  = 4'd10;
    localparam logic [3:0] OP_NOR   = 4'd11;
    localparam logic [3:0] OP_ANDC1 = 4'd12;
    localparam logic [3:0] OP_ANDC2 = 4'd13;
    localparam logic [3:0] OP_ORC1  = 4'd14;
    localparam logic [3:0] OP_ORC2  = 4'd15;

    typedef struct packed {
        logic [3:0] bool_op;
        logic [2:0] x_bit_offset;
        logic [2:0] y_bit_offset;
        logic [2:0] dest_bit_offset;
    } t_cfg;

    typedef struct packed {
        logic               out_last;
        logic [INDEX_W-1:0] out_index;
        logic [7:0]         out_byte;
    } t_res;

    typedef struct packed {
        logic                  busy;
        logic                  at_start;
    } t_dp_stat;

    function automatic logic [7:0] bool_apply(input logic [3:0] op,
                                              input logic [7:0] a,
                                              input logic [7:0] b);
        logic [7:0] r;
        case (op)
            OP_CLR:   r = 8'h00;
            OP_SET:   r = 8'hFF;
            OP_1:     r = a;
            OP_2:     r = b;
            OP_C1:    r = ~a;
            OP_C2:    r = ~b;
            OP_AND:   r = a & b;
            OP_IOR:   r = a | b;
            OP_XOR:   r = a ^ b;
            OP_EQV:   r = ~(a ^ b);
            OP_NAND:  r = ~(a & b);
            OP_NOR:   r = ~(a | b);
            OP_ANDC1: r = ~a & b;
            OP_ANDC2: r = a & ~b;
            OP_ORC1:  r = ~a | b;
            default:  r = a | ~b;
        endcase
        return r;
    endfunction

    // byte that starts at bit offset off of the pair {hi, lo}, MSB first
    function automatic logic [7:0] align_byte(input logic [7:0] hi,
                                              input logic [7:0] lo,
                                              input logic [2:0] off);
        logic [15:0] t;
        t = {hi, lo} << off;
        return t[15:8];
    endfunction

    // top n bits of a byte set
    function automatic logic [7:0] top_mask(input logic [2:0] n);
        logic [15:0] t;
        t = 16'hFF00 >> n;
        return t[7:0];
    endfunction

endpackage

### design/bar_cfg.sv
// ---------------------------------------------------------------------------
// bar_cfg
// Configuration registers; flags a stream restart on every valid write.
// ---------------------------------------------------------------------------
module bar_cfg
    import bar_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [LENGTH_WIDTH-1:0] i_cfg_wdata,
    output t_cfg                    o_cfg,
    output logic [LENGTH_WIDTH-1:0] o_length,
    output logic                    o_clear
);

    t_cfg                    r_cfg;
    logic [LENGTH_WIDTH-1:0] r_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= '0;
            r_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_BOOL_OP:     r_cfg.bool_op         <= i_cfg_wdata[3:0];
                CFG_X_OFFSET:    r_cfg.x_bit_offset    <= i_cfg_wdata[2:0];
                CFG_Y_OFFSET:    r_cfg.y_bit_offset    <= i_cfg_wdata[2:0];
                CFG_DEST_OFFSET: r_cfg.dest_bit_offset <= i_cfg_wdata[2:0];
                CFG_LENGTH:      r_length              <= i_cfg_wdata;
                default:         ;
            endcase
        end
    end

    // restart on any write to a defined register
    assign o_clear  = i_cfg_we && (i_cfg_addr <= CFG_LENGTH);
    assign o_cfg    = r_cfg;
    assign o_length = r_length;

endmodule

### design/bar_dp.sv
// ---------------------------------------------------------------------------
// bar_dp
// Input register, stream state and the align / boolean / merge datapath.
// ---------------------------------------------------------------------------
module bar_dp
    import bar_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic [LENGTH_WIDTH-1:0] i_length,
    input  logic                    i_clear,
    input  logic                    i_accept,
    input  logic [7:0]              i_x_byte,
    input  logic [7:0]              i_y_byte,
    input  logic [7:0]              i_dest_byte,
    output logic [1:0]              o_push,
    output t_res                    o_res0,
    output t_res                    o_res1,
    output t_dp_stat                o_stat
);

    localparam int CW = LENGTH_WIDTH - 2;
    localparam int NW = LENGTH_WIDTH - 3;

    logic          r_in_valid;
    logic [7:0]    r_x, r_y, r_d;
    logic [7:0]    r_prev_x, r_prev_y, r_pending;
    logic [CW-1:0] r_count;

    logic [7:0]    n_prev_x, n_prev_y, n_pending;
    logic [CW-1:0] n_count;

    logic [NW-1:0]        nfull;
    logic [2:0]           rem;
    logic [CW-1:0]        steps;
    logic [CW-1:0]        idx_i;
    logic [CW+INDEX_W-1:0] ext_i, ext_k;
    logic [7:0]           ax, ay, op_byte, fin_byte, cur, mrem, keep;
    logic [15:0]          sh;
    logic [7:0]           first_b, next_b;

    assign nfull = i_length[LENGTH_WIDTH-1:3];
    assign rem   = i_length[2:0];
    assign steps = {1'b0, nfull} + CW'(rem != 3'd0);
    assign idx_i = r_count - CW'(1);
    assign ext_i = {{INDEX_W{1'b0}}, idx_i};
    assign ext_k = {{INDEX_W{1'b0}}, r_count};

    always_comb begin
        ax      = align_byte(r_prev_x, r_x, i_cfg.x_bit_offset);
        ay      = align_byte(r_prev_y, r_y, i_cfg.y_bit_offset);
        op_byte = bool_apply(i_cfg.bool_op, ax, ay);
        cur     = align_byte(r_pending, r_d, i_cfg.dest_bit_offset);
        mrem    = top_mask(rem);
        // final partial byte: keep destination bits past the length
        fin_byte = (idx_i == {1'b0, nfull}) ? ((cur & ~mrem) | (op_byte & mrem)) : op_byte;
        keep     = top_mask(i_cfg.dest_bit_offset);
        sh       = {fin_byte, 8'h00} >> i_cfg.dest_bit_offset;
        first_b  = (r_pending & keep) | (sh[15:8] & ~keep);
        next_b   = (r_d & ~keep) | (sh[7:0] & keep);
    end

    always_comb begin
        o_push    = 2'd0;
        o_res0    = '{out_last: 1'b0, out_index: ext_i[INDEX_W-1:0], out_byte: first_b};
        o_res1    = '{out_last: 1'b1, out_index: ext_k[INDEX_W-1:0], out_byte: next_b};
        n_prev_x  = r_prev_x;
        n_prev_y  = r_prev_y;
        n_pending = r_pending;
        n_count   = r_count;
        if (r_in_valid) begin
            if (r_count == '0) begin
                n_pending = r_d;
                n_prev_x  = r_x;
                n_prev_y  = r_y;
                if (steps == '0) begin
                    // zero length: pass destination byte 0 through as the last
                    o_push    = 2'd1;
                    o_res0    = '{out_last: 1'b1, out_index: '0, out_byte: r_d};
                    n_pending = '0;
                    n_prev_x  = '0;
                    n_prev_y  = '0;
                end else begin
                    n_count = CW'(1);
                end
            end else if (r_count >= steps) begin
                o_push    = 2'd2;
                n_pending = '0;
                n_prev_x  = '0;
                n_prev_y  = '0;
                n_count   = '0;
            end else begin
                o_push    = 2'd1;
                n_pending = next_b;
                n_prev_x  = r_x;
                n_prev_y  = r_y;
                n_count   = r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_pending  <= '0;
            r_count    <= '0;
        end else begin
            r_in_valid <= i_accept;
            if (i_clear) begin
                r_prev_x  <= '0;
                r_prev_y  <= '0;
                r_pending <= '0;
                r_count   <= '0;
            end else begin
                r_prev_x  <= n_prev_x;
                r_prev_y  <= n_prev_y;
                r_pending <= n_pending;
                r_count   <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_x <= i_x_byte;
            r_y <= i_y_byte;
            r_d <= i_dest_byte;
        end
    end

    assign o_stat = '{busy: r_in_valid, at_start: (r_count == '0)};

endmodule

### design/bar_fifo.sv
// ---------------------------------------------------------------------------
// bar_fifo
// Result queue: takes up to two items per cycle, hands out one.
// ---------------------------------------------------------------------------
module bar_fifo
    import bar_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_push,
    input  t_res                  i_res0,
    input  t_res                  i_res1,
    input  logic                  i_pop,
    output t_res                  o_head,
    output logic                  o_valid,
    output logic [FIFO_CNT_W-1:0] o_count
);

    t_res                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wr + FIFO_PTR_W'(1)] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_PTR_W'(i_push);
            r_rd    <= r_rd + FIFO_PTR_W'(pop_ok);
            r_count <= r_count + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(pop_ok);
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

### design/bit_aligned_raster_op_core.sv
// ---------------------------------------------------------------------------
// bit_aligned_raster_op_core
// Bit-aligned raster op: align two source byte streams, combine them with one
// of sixteen boolean operations and merge the result into the destination.
// ---------------------------------------------------------------------------
// Feed one item per byte index: raw first-source, second-source and
// destination bytes at the same index, starting at index 0. An operation of
// length_bits bits takes ceil(length_bits/8)+1 items; the first item emits
// nothing (unless the length is zero), each later item emits the finished
// destination byte before it, and the final item also emits the last byte
// with tlast set. Destination bits outside the length come back unchanged.
// The core accepts one item per clock while tready is high: each item is
// registered, processed against the held previous bytes, and its one or
// two result items drop into an eight-entry output queue. tready falls only
// when the queue lacks room for two more results beyond the one item in
// flight, so with a consumer that takes one item per cycle the rate is one
// item per clock; the item that ends an operation delivers two results.
// Writing any defined register restarts the operation; write registers only
// while the core is idle. Writes to undefined indexes are dropped. Output
// byte indexes wrap modulo 2^18.
// ---------------------------------------------------------------------------
`include "bit_aligned_raster_op_core_macros.svh"

module bit_aligned_raster_op_core
    import bar_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [LENGTH_WIDTH-1:0] i_cfg_wdata,
    // input items
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [23:0]             s_axis_tdata,  // x_byte[7:0], y_byte[15:8], dest_byte[23:16]
    // result items
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [31:0]             m_axis_tdata,  // out_byte[7:0], out_index[25:8], zero pad
    output logic                    m_axis_tlast   // out_last
);

    t_cfg                    cfg;
    logic [LENGTH_WIDTH-1:0] length;
    logic                    cfg_clear;
    logic                    accept;
    logic [1:0]              push;
    t_res                    res0, res1, head;
    t_dp_stat                dp_stat;
    logic [FIFO_CNT_W-1:0]   q_count;
    logic [FIFO_CNT_W:0]     q_need;

    bar_cfg #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg),
        .o_length    (length),
        .o_clear     (cfg_clear)
    );

    // reserve two queue slots for the item in flight and two for a new one
    assign q_need        = {1'b0, q_count} + (dp_stat.busy ? (FIFO_CNT_W+1)'(2) : '0);
    assign s_axis_tready = (q_need <= (FIFO_CNT_W+1)'(FIFO_DEPTH - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;

    bar_dp #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_length    (length),
        .i_clear     (cfg_clear),
        .i_accept    (accept),
        .i_x_byte    (s_axis_tdata[7:0]),
        .i_y_byte    (s_axis_tdata[15:8]),
        .i_dest_byte (s_axis_tdata[23:16]),
        .o_push      (push),
        .o_res0      (res0),
        .o_res1      (res1),
        .o_stat      (dp_stat)
    );

    bar_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_pop   (m_axis_tready),
        .o_head  (head),
        .o_valid (m_axis_tvalid),
        .o_count (q_count)
    );

    assign m_axis_tdata = {6'b0, head.out_index, head.out_byte};
    assign m_axis_tlast = head.out_last;

    // queue never overflows
    `BAR_ASSERT_NEVER(a_q_overflow, q_count > FIFO_CNT_W'(FIFO_DEPTH))
    // ready is withheld once the queue is short of room
    `BAR_ASSERT_IMPLY(a_ready_room, s_axis_tready, q_need <= (FIFO_CNT_W+1)'(FIFO_DEPTH - 2))
    // a write to a defined register restarts the operation
    `BAR_ASSERT_NEXT(a_cfg_restart, cfg_clear, dp_stat.at_start)
    // results only come from an item that was taken the cycle before
    `BAR_ASSERT_IMPLY(a_push_src, push != 2'd0, dp_stat.busy)

endmodule
